>>> sv/chl_pkg.sv
// Shared types, token class codes and keyword table for the C++ highlight lexer.
// Depends on nothing; used by chl_lexer, chl_outq and cpp_highlight_lexer_unit.
package chl_pkg;

  // Token class codes
  localparam logic [2:0] CL_DEFAULT  = 3'd0;
  localparam logic [2:0] CL_KEYWORD  = 3'd1;
  localparam logic [2:0] CL_STRING   = 3'd2;
  localparam logic [2:0] CL_COMMENT  = 3'd3;
  localparam logic [2:0] CL_NUMBER   = 3'd4;
  localparam logic [2:0] CL_OPERATOR = 3'd5;

  // Input item
  typedef struct packed {
    logic [15:0] ch;
    logic        has_char;
    logic        line_end;
  } chl_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]  token_class;
    logic [11:0] start_col;
    logic [12:0] token_len;
    logic        line_done;
    logic        run_last;
    logic        too_long;
  } chl_out_t;

  // Results caused by one item, handed from the lexer to the output queue
  typedef struct packed {
    logic [1:0]          cnt;
    chl_out_t [1:0]      tok;
  } chl_res_t;

  // Keyword table: text right-justified, first character in the highest used byte
  localparam int KW_COUNT = 36;
  localparam int KW_MAX   = 9;

  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "int", "float", "double", "char", "bool", "void",
    "if", "else", "for", "while", "do", "switch", "case", "break", "continue",
    "return", "class", "struct", "namespace", "public", "private", "protected",
    "const", "static", "virtual", "override", "new", "delete", "this",
    "true", "false", "nullptr", "auto", "typedef", "using", "template"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    3, 5, 6, 4, 4, 4,
    2, 4, 3, 5, 2, 6, 4, 5, 8,
    6, 5, 6, 9, 6, 7, 9,
    5, 6, 7, 8, 3, 6, 4,
    4, 5, 7, 4, 7, 5, 8
  };

  // Parallel compare of a word against every table entry
  function automatic logic is_keyword(input logic [KW_MAX-1:0][31:0] w,
                                      input logic [31:0] n);
    logic hit;
    logic m;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      m = (n == 32'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX; i++) begin
        if (i < KW_LEN[k]) begin
          m = m & (w[i] == 32'(KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]));
        end
      end
      hit = hit | m;
    end
    return hit;
  endfunction

  // ASCII character classes
  function automatic logic is_digit(input logic [31:0] c);
    return (c >= 32'h30) && (c <= 32'h39);
  endfunction

  function automatic logic is_alpha(input logic [31:0] c);
    return ((c >= 32'h61) && (c <= 32'h7a)) || ((c >= 32'h41) && (c <= 32'h5a));
  endfunction

  function automatic logic is_space(input logic [31:0] c);
    return (c == 32'd32) || ((c >= 32'd9) && (c <= 32'd13));
  endfunction

  function automatic logic is_hex(input logic [31:0] c);
    return is_digit(c) || ((c >= 32'h61) && (c <= 32'h66)) ||
           ((c >= 32'h41) && (c <= 32'h46));
  endfunction

endpackage

>>> sv/chl_lexer.sv
// Lexer state and single-pass token logic: one character per accepted item.
// Depends on chl_pkg (item types, class codes, keyword table).
module chl_lexer #(
  parameter int MAX_LINE    = 4096,
  parameter int KEYWORD_LEN = 9,
  parameter int CHAR_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  chl_pkg::chl_in_t  item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_mode_i,
  output chl_pkg::chl_res_t res_o
);
  import chl_pkg::*;

  localparam int CW  = $clog2(MAX_LINE + 1);
  localparam int TW  = $clog2(MAX_LINE);
  localparam int WLW = $clog2(KEYWORD_LEN + 2);
  localparam int WIW = $clog2(KEYWORD_LEN);
  localparam logic [CW-1:0]  COL_MAX   = CW'(MAX_LINE);
  localparam logic [TW-1:0]  START_SAT = TW'(MAX_LINE - 1);
  localparam logic [WLW-1:0] WL_LIM    = WLW'(KEYWORD_LEN);

  // Lexer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SLASH   = 4'd1;
  localparam logic [3:0] ST_OP      = 4'd2;
  localparam logic [3:0] ST_COMMENT = 4'd3;
  localparam logic [3:0] ST_STR     = 4'd4;
  localparam logic [3:0] ST_STR_ESC = 4'd5;
  localparam logic [3:0] ST_ZERO    = 4'd6;
  localparam logic [3:0] ST_DEC     = 4'd7;
  localparam logic [3:0] ST_HEX     = 4'd8;
  localparam logic [3:0] ST_IDENT   = 4'd9;

  // Class of the token open in a state; top bit marks a word awaiting keyword lookup
  function automatic logic [3:0] st_class(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      ST_SLASH, ST_OP:      r = {1'b0, CL_OPERATOR};
      ST_COMMENT:           r = {1'b0, CL_COMMENT};
      ST_STR, ST_STR_ESC:   r = {1'b0, CL_STRING};
      ST_ZERO, ST_DEC,
      ST_HEX:               r = {1'b0, CL_NUMBER};
      ST_IDENT:             r = {1'b1, CL_DEFAULT};
      default:              r = {1'b0, CL_DEFAULT};
    endcase
    return r;
  endfunction

  // State registers
  logic                 cpp_mode_q;
  logic                 lmode_q, lmode_d;
  logic                 open_q, open_d;
  logic                 too_q, too_d;
  logic [3:0]           st_q, st_d;
  logic [CW-1:0]        col_q, col_d;
  logic [TW-1:0]        ts_q, ts_d;
  logic [WLW-1:0]       wl_q, wl_d;
  logic                 dot_q, dot_d;
  logic                 qs_q, qs_d;
  logic                 had_q, had_d;
  logic                 hv_q, hv_d;
  logic [2:0]           hcls_q, hcls_d;
  logic [TW-1:0]        hst_q, hst_d;
  logic [CW-1:0]        hlen_q, hlen_d;
  logic [CHAR_BITS-1:0] word_q [KEYWORD_LEN];

  // Working values
  logic [CHAR_BITS-1:0] c;
  logic [31:0]          cw;
  logic [31:0]          quote;
  logic                 has, last, mode, used, close_now;
  logic [CW-1:0]        col_pre, close_end, col1;
  logic [TW-1:0]        start, ts1;
  logic [3:0]           st1, scls;
  logic [WLW-1:0]       wl1;
  logic                 dot1, qs1, too1;
  logic                 hv1, hpend1;
  logic [2:0]           hcls1;
  logic [TW-1:0]        hst1;
  logic [CW-1:0]        hlen1;
  logic                 wr_en;
  logic [WIW-1:0]       wr_idx;
  logic [1:0]           cnt;
  logic [2:0]           e_cls  [2];
  logic                 e_pend [2];
  logic [TW-1:0]        e_st   [2];
  logic [CW-1:0]        e_len  [2];
  logic [KW_MAX-1:0][31:0] kw_w;
  logic                 kw_hit;

  assign c     = CHAR_BITS'(item_i.ch);
  assign cw    = 32'(c);
  assign has   = item_i.has_char;
  assign last  = item_i.line_end;
  assign quote = qs_q ? 32'h27 : 32'h22;

  // Character step, token close and line-end handling
  always_comb begin
    mode      = open_q ? lmode_q : cpp_mode_q;
    col1      = col_q;
    too1      = too_q;
    col_pre   = col_q;
    start     = (col_q < COL_MAX) ? col_q[TW-1:0] : START_SAT;
    st1       = st_q;
    ts1       = ts_q;
    wl1       = wl_q;
    dot1      = dot_q;
    qs1       = qs_q;
    hv1       = hv_q;
    hcls1     = hcls_q;
    hpend1    = 1'b0;
    hst1      = hst_q;
    hlen1     = hlen_q;
    used      = 1'b0;
    close_now = 1'b0;
    close_end = col_pre;
    scls      = '0;
    wr_en     = 1'b0;
    wr_idx    = '0;
    cnt       = 2'd0;
    for (int j = 0; j < 2; j++) begin
      e_cls[j]  = CL_DEFAULT;
      e_pend[j] = 1'b0;
      e_st[j]   = '0;
      e_len[j]  = '0;
    end

    // column count, saturating at the line limit
    if (has) begin
      if (col_q >= COL_MAX) too1 = 1'b1;
      else                  col1 = col_q + CW'(1);
    end

    if (has && mode) begin
      case (st_q)
        ST_SLASH: begin
          if (cw == 32'h2f) begin
            st1  = ST_COMMENT;
            used = 1'b1;
          end else begin
            close_now = 1'b1;
          end
        end
        ST_OP: close_now = 1'b1;
        ST_COMMENT: used = 1'b1;
        ST_STR: begin
          used = 1'b1;
          if (cw == quote) begin
            close_now = 1'b1;
            close_end = col1;
          end else if (cw == 32'h5c) begin
            st1 = ST_STR_ESC;
          end
        end
        ST_STR_ESC: begin
          used = 1'b1;
          st1  = ST_STR;
        end
        ST_ZERO, ST_DEC: begin
          if (st_q == ST_ZERO && (cw == 32'h78 || cw == 32'h58)) begin
            st1  = ST_HEX;
            used = 1'b1;
          end else if (is_digit(cw)) begin
            st1  = ST_DEC;
            used = 1'b1;
          end else if (cw == 32'h2e && !dot_q) begin
            st1  = ST_DEC;
            dot1 = 1'b1;
            used = 1'b1;
          end else if ((cw == 32'h66 || cw == 32'h46) && last) begin
            used      = 1'b1;
            close_now = 1'b1;
            close_end = col1;
          end else begin
            close_now = 1'b1;
          end
        end
        ST_HEX: begin
          if (is_hex(cw)) used = 1'b1;
          else            close_now = 1'b1;
        end
        ST_IDENT: begin
          if (is_alpha(cw) || is_digit(cw) || cw == 32'h5f) begin
            used = 1'b1;
            if (wl_q < WL_LIM) begin
              wr_en  = 1'b1;
              wr_idx = wl_q[WIW-1:0];
            end
            if (wl_q <= WL_LIM) wl1 = wl_q + WLW'(1);
          end else begin
            close_now = 1'b1;
          end
        end
        default: ;
      endcase

      // close the open token into the hold slot
      if (close_now) begin
        scls   = st_class(st_q);
        hv1    = 1'b1;
        hcls1  = scls[2:0];
        hpend1 = scls[3];
        hst1   = ts_q;
        hlen1  = (close_end >= CW'(ts_q)) ? close_end - CW'(ts_q) : '0;
        st1    = ST_IDLE;
      end

      // a new token flushes the held one and opens itself
      if (!used && !is_space(cw)) begin
        if (hv1) begin
          e_cls[cnt[0]]  = hcls1;
          e_pend[cnt[0]] = hpend1;
          e_st[cnt[0]]   = hst1;
          e_len[cnt[0]]  = hlen1;
          cnt            = cnt + 2'd1;
        end
        hv1 = 1'b0;
        ts1 = start;
        if (cw == 32'h2f) begin
          st1 = ST_SLASH;
        end else if (cw == 32'h22 || cw == 32'h27) begin
          st1 = ST_STR;
          qs1 = (cw == 32'h27);
        end else if (is_digit(cw)) begin
          st1  = (cw == 32'h30) ? ST_ZERO : ST_DEC;
          dot1 = 1'b0;
        end else if (is_alpha(cw) || cw == 32'h5f) begin
          st1    = ST_IDENT;
          wr_en  = 1'b1;
          wr_idx = '0;
          wl1    = WLW'(1);
        end else begin
          st1 = ST_OP;
        end
      end
    end

    // line end: close what is open, flush, or report the whole line
    if (last && mode) begin
      if (st1 != ST_IDLE) begin
        scls           = st_class(st1);
        e_cls[cnt[0]]  = scls[2:0];
        e_pend[cnt[0]] = scls[3];
        e_st[cnt[0]]   = ts1;
        e_len[cnt[0]]  = (col1 >= CW'(ts1)) ? col1 - CW'(ts1) : '0;
        cnt            = cnt + 2'd1;
      end else if (hv1) begin
        e_cls[cnt[0]]  = hcls1;
        e_pend[cnt[0]] = hpend1;
        e_st[cnt[0]]   = hst1;
        e_len[cnt[0]]  = hlen1;
        cnt            = cnt + 2'd1;
      end
    end
    if (last && cnt == 2'd0 && !had_q) begin
      e_cls[0] = CL_DEFAULT;
      e_st[0]  = '0;
      e_len[0] = col1;
      cnt      = 2'd1;
    end
  end

  // Keyword lookup on the word as it stands after this item
  always_comb begin
    for (int i = 0; i < KW_MAX; i++) begin
      kw_w[i] = (wr_en && wr_idx == WIW'(i)) ? cw : 32'(word_q[i]);
    end
    kw_hit = (wl1 <= WL_LIM) && is_keyword(kw_w, 32'(wl1));
  end

  // Next state, with the line-end clear
  always_comb begin
    lmode_d = open_q ? lmode_q : cpp_mode_q;
    open_d  = 1'b1;
    too_d   = too1;
    st_d    = st1;
    col_d   = col1;
    ts_d    = ts1;
    wl_d    = wl1;
    dot_d   = dot1;
    qs_d    = qs1;
    had_d   = had_q | (cnt != 2'd0);
    hv_d    = hv1;
    hcls_d  = hpend1 ? (kw_hit ? CL_KEYWORD : CL_DEFAULT) : hcls1;
    hst_d   = hst1;
    hlen_d  = hlen1;
    if (last) begin
      open_d = 1'b0;
      too_d  = 1'b0;
      st_d   = ST_IDLE;
      col_d  = '0;
      ts_d   = '0;
      wl_d   = '0;
      dot_d  = 1'b0;
      qs_d   = 1'b0;
      had_d  = 1'b0;
      hv_d   = 1'b0;
    end
  end

  // Result formatting
  always_comb begin
    logic [31:0] st_w;
    logic [31:0] len_w;
    res_o.cnt = fire_i ? cnt : 2'd0;
    for (int j = 0; j < 2; j++) begin
      st_w  = 32'(e_st[j]);
      len_w = 32'(e_len[j]);
      res_o.tok[j].token_class = e_pend[j] ? (kw_hit ? CL_KEYWORD : CL_DEFAULT) : e_cls[j];
      res_o.tok[j].start_col   = st_w[11:0];
      res_o.tok[j].token_len   = len_w[12:0];
      res_o.tok[j].too_long    = too1;
      res_o.tok[j].run_last    = (cnt == 2'(j + 1));
      res_o.tok[j].line_done   = (cnt == 2'(j + 1)) && last;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      cpp_mode_q <= cfg_mode_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmode_q <= 1'b0;
      open_q  <= 1'b0;
      too_q   <= 1'b0;
      st_q    <= ST_IDLE;
      col_q   <= '0;
      ts_q    <= '0;
      wl_q    <= '0;
      dot_q   <= 1'b0;
      qs_q    <= 1'b0;
      had_q   <= 1'b0;
      hv_q    <= 1'b0;
    end else if (fire_i) begin
      lmode_q <= lmode_d;
      open_q  <= open_d;
      too_q   <= too_d;
      st_q    <= st_d;
      col_q   <= col_d;
      ts_q    <= ts_d;
      wl_q    <= wl_d;
      dot_q   <= dot_d;
      qs_q    <= qs_d;
      had_q   <= had_d;
      hv_q    <= hv_d;
    end
  end

  // Held token payload and word store
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hcls_q <= hcls_d;
      hst_q  <= hst_d;
      hlen_q <= hlen_d;
      if (wr_en) word_q[wr_idx] <= c;
    end
  end

  // Every line end reports at least one token
  a_line_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.line_end |-> res_o.cnt != 2'd0)
    else $error("line end without a token");

  // A finished line leaves no column count and no held token behind
  a_line_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.line_end |=> col_q == '0 && !hv_q)
    else $error("line state not cleared");

  // A held token only waits while no other token is open
  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> st_q == ST_IDLE)
    else $error("held token while a token is open");

endmodule

>>> sv/chl_outq.sv
// Four-entry queue: up to two results in per cycle, one out per pop.
// Depends on chl_pkg (result types).
module chl_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chl_pkg::chl_res_t  push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output chl_pkg::chl_out_t  data_o
);
  import chl_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  chl_out_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q + PW'(push_i.cnt);
    rd_d  = rd_q + PW'(pop_i);
    cnt_d = cnt_q + (PW+1)'(push_i.cnt) - (PW+1)'(pop_i);
  end

  assign full_o  = (cnt_q > (PW+1)'(DEPTH - 2));
  assign valid_o = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage: the first result at the write pointer, the second after it
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.tok[0];
    if (push_i.cnt == 2'd2) mem_q[wr_q + PW'(1)] <= push_i.tok[1];
  end

  assign data_o = mem_q[rd_q];

  // Fill never passes the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH))
    else $error("result queue overflow");

  // A push arrives only while two slots are free
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> cnt_q <= (PW+1)'(DEPTH - 2))
    else $error("push into a full queue");

  // Pops only from a non-empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from an empty queue");

endmodule

>>> sv/cpp_highlight_lexer_unit.sv
// Top level of the streaming C++ highlight lexer: lexer core plus result queue.
// Depends on chl_pkg, chl_lexer and chl_outq.
//
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_stall_o   in_data_i  (chl_in_t: ch, has_char, line_end)
//  out      out  out_valid_o/out_stall_i out_data_o (chl_out_t token fields)
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (cpp_mode)
//
// One character per cycle unless stalled: each transfer is lexed in the cycle it is
// taken, and its one or two results go in order into a four-entry queue.
// Input stalls while fewer than two queue slots are free; at one result per cycle
// out while out_stall_i is low, a line sustains one item per cycle; lines with many
// short tokens slow to the output rate of one token per cycle.
// Reset clears the lexer state, the queue and cpp_mode; no clearing pass is needed.
module cpp_highlight_lexer_unit #(
  parameter int MAX_LINE    = 4096,
  parameter int KEYWORD_LEN = 9,
  parameter int CHAR_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  chl_pkg::chl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output chl_pkg::chl_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import chl_pkg::*;

  logic     in_fire;
  logic     q_full;
  chl_res_t res;

  // Input and output transfers
  assign in_stall_o  = q_full;
  assign in_fire     = in_valid_i & ~q_full;
  assign cfg_ready_o = 1'b1;

  chl_lexer #(
    .MAX_LINE    (MAX_LINE),
    .KEYWORD_LEN (KEYWORD_LEN),
    .CHAR_BITS   (CHAR_BITS)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_mode_i (cfg_data_i),
    .res_o      (res)
  );

  chl_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .pop_i   (out_valid_o & ~out_stall_i),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
